>>> rtl/core/objseg_pkg.sv
// ----------------------------------------------------------------------------
// objseg_pkg: shared types and constants of the object segmenter
// Holds register indexes, reset values, field widths and the job record that
// passes from the classifier through the queue to the result serializer.
// ----------------------------------------------------------------------------
package objseg_pkg;

   localparam int LEN_BITS    = 13;
   localparam int OBJ_BITS    = 28;
   localparam int INDEX_BITS  = 15;
   localparam int TID_BITS    = 16;
   localparam int DGT_BITS    = 4;
   localparam int REP_BITS    = 3;
   localparam int CSR_IDX_BITS = 1;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [LEN_BITS-1:0]   SEG_SIZE_RESET  = 13'd1024;
   localparam logic [REP_BITS-1:0]   REP_COUNT_RESET = 3'd0;
   localparam logic [INDEX_BITS-1:0] SEG_INDEX_MAX   = 15'h7FFF;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEG_SIZE  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REP_COUNT = 1'b1;

   // one accepted input item, classified: a data byte, optionally preceded by
   // a two-byte segment header
   typedef struct packed {
      logic [7:0]            data_byte;
      logic                  has_hdr;
      logic [15:0]           hdr_word;
      logic [INDEX_BITS-1:0] seg_index;
      logic                  last_segment;
      logic                  end_of_segment;
      logic                  overrun;
      logic [TID_BITS-1:0]   transport_id;
      logic [DGT_BITS-1:0]   datagroup_type;
   } job_type;

endpackage

>>> rtl/core/objseg_if.sv
// ----------------------------------------------------------------------------
// objseg_if: request and response channels of the object segmenter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface objseg_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic [27:0] object_length;
   logic [15:0] transport_id;
   logic [3:0]  datagroup_type;

   modport source (output valid, data_byte, first_byte, object_length, transport_id,
                   datagroup_type, input ready);
   modport sink   (input valid, data_byte, first_byte, object_length, transport_id,
                   datagroup_type, output ready);
endinterface

interface objseg_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        is_header_byte;
   logic [14:0] segment_index;
   logic        last_segment;
   logic        end_of_segment;
   logic [15:0] out_transport_id;
   logic [3:0]  out_datagroup_type;
   logic        overrun;
   logic        last;

   modport source (output valid, out_byte, is_header_byte, segment_index, last_segment,
                   end_of_segment, out_transport_id, out_datagroup_type, overrun, last,
                   input ready);
   modport sink   (input valid, out_byte, is_header_byte, segment_index, last_segment,
                   end_of_segment, out_transport_id, out_datagroup_type, overrun, last,
                   output ready);
endinterface

>>> rtl/core/objseg_front.sv
// ----------------------------------------------------------------------------
// objseg_front: input classifier
// Tracks object and segment byte counts and turns each accepted byte into a
// job record: overrun, plain data byte, or data byte opening a segment.
// ----------------------------------------------------------------------------
module objseg_front (
   input  logic                                   clock,
   input  logic                                   reset,
   objseg_req_if.sink                             req,
   input  logic [objseg_pkg::LEN_BITS-1:0]        segment_size,
   input  logic [objseg_pkg::REP_BITS-1:0]        repetition_count,
   input  logic                                   queue_full,
   output logic                                   push,
   output objseg_pkg::job_type                    job
);

   logic [objseg_pkg::OBJ_BITS-1:0]   remain_ff, remain_in, remain0;
   logic [objseg_pkg::LEN_BITS-1:0]   left_ff, left_in, left0, left1, size, seglen;
   logic [objseg_pkg::INDEX_BITS-1:0] index_ff, index_in, index0, index1;
   logic [objseg_pkg::TID_BITS-1:0]   tid_ff, tid_in;
   logic [objseg_pkg::DGT_BITS-1:0]   dgt_ff, dgt_in;
   logic                              opening, lastseg;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   always_comb begin
      remain0 = req.first_byte ? req.object_length : remain_ff;
      left0   = req.first_byte ? '0 : left_ff;
      index0  = req.first_byte ? '0 : index_ff;
      tid_in  = req.first_byte ? req.transport_id : tid_ff;
      dgt_in  = req.first_byte ? req.datagroup_type : dgt_ff;

      size    = (segment_size == '0) ? objseg_pkg::LEN_BITS'(1) : segment_size;
      seglen  = (remain0 < {{(objseg_pkg::OBJ_BITS-objseg_pkg::LEN_BITS){1'b0}}, size})
                ? remain0[objseg_pkg::LEN_BITS-1:0] : size;
      opening = (left0 == '0);
      left1   = opening ? seglen : left0;
      index1  = (opening && !req.first_byte && index0 != objseg_pkg::SEG_INDEX_MAX)
                ? index0 + objseg_pkg::INDEX_BITS'(1) : index0;
      lastseg = ({{(objseg_pkg::OBJ_BITS-objseg_pkg::LEN_BITS){1'b0}}, left1} == remain0);

      job.data_byte      = req.data_byte;
      job.transport_id   = tid_in;
      job.datagroup_type = dgt_in;
      job.hdr_word       = {repetition_count, seglen};

      if (remain0 == '0) begin
         // past the end of the object: pass through, hold counts
         job.has_hdr        = 1'b0;
         job.seg_index      = index0;
         job.last_segment   = 1'b0;
         job.end_of_segment = 1'b0;
         job.overrun        = 1'b1;
         remain_in          = remain0;
         left_in            = left0;
         index_in           = index0;
      end else begin
         job.has_hdr        = opening;
         job.seg_index      = index1;
         job.last_segment   = lastseg;
         job.end_of_segment = (left1 == objseg_pkg::LEN_BITS'(1));
         job.overrun        = 1'b0;
         remain_in          = remain0 - objseg_pkg::OBJ_BITS'(1);
         left_in            = left1 - objseg_pkg::LEN_BITS'(1);
         index_in           = index1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         left_ff   <= '0;
         index_ff  <= '0;
         tid_ff    <= '0;
         dgt_ff    <= '0;
      end else if (push) begin
         remain_ff <= remain_in;
         left_ff   <= left_in;
         index_ff  <= index_in;
         tid_ff    <= tid_in;
         dgt_ff    <= dgt_in;
      end
   end

endmodule

>>> rtl/core/objseg_fifo.sv
// ----------------------------------------------------------------------------
// objseg_fifo: job queue
// Small register queue between classifier and serializer.
// ----------------------------------------------------------------------------
module objseg_fifo #(
   parameter int DEPTH = objseg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  objseg_pkg::job_type push_job,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output objseg_pkg::job_type head_job
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   objseg_pkg::job_type       mem_ff [DEPTH];
   logic [PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head_job  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/objseg_back.sv
// ----------------------------------------------------------------------------
// objseg_back: result serializer
// Expands each job into one or three response bytes into an output register.
// ----------------------------------------------------------------------------
module objseg_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  objseg_pkg::job_type job,
   output logic                pop,
   objseg_rsp_if.source        rsp
);

   localparam logic [1:0] PH_HI   = 2'd0;
   localparam logic [1:0] PH_LO   = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic       can_load, emit, is_hdr;
   logic [7:0] byte_sel;

   logic [7:0]                        byte_ff;
   logic                              hdr_ff, lastseg_ff, eos_ff, ovr_ff, last_ff;
   logic [objseg_pkg::INDEX_BITS-1:0] index_ff;
   logic [objseg_pkg::TID_BITS-1:0]   tid_ff;
   logic [objseg_pkg::DGT_BITS-1:0]   dgt_ff;

   assign can_load = !valid_ff || rsp.ready;
   assign emit     = job_valid && can_load;
   assign is_hdr   = job.has_hdr && (phase_ff != PH_DATA);
   assign pop      = emit && !is_hdr;

   always_comb begin
      byte_sel = job.data_byte;
      if (is_hdr) begin
         byte_sel = (phase_ff == PH_HI) ? job.hdr_word[15:8] : job.hdr_word[7:0];
      end
      phase_in = phase_ff;
      if (emit) begin
         if (!is_hdr) begin
            phase_in = PH_HI;
         end else begin
            unique case (phase_ff)
               PH_HI:   phase_in = PH_LO;
               PH_LO:   phase_in = PH_DATA;
               default: phase_in = PH_HI;
            endcase
         end
      end
      valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HI;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff    <= byte_sel;
         hdr_ff     <= is_hdr;
         index_ff   <= job.seg_index;
         lastseg_ff <= job.last_segment;
         eos_ff     <= !is_hdr && job.end_of_segment;
         tid_ff     <= job.transport_id;
         dgt_ff     <= job.datagroup_type;
         ovr_ff     <= !is_hdr && job.overrun;
         last_ff    <= !is_hdr;
      end
   end

   assign rsp.valid              = valid_ff;
   assign rsp.out_byte           = byte_ff;
   assign rsp.is_header_byte     = hdr_ff;
   assign rsp.segment_index      = index_ff;
   assign rsp.last_segment       = lastseg_ff;
   assign rsp.end_of_segment     = eos_ff;
   assign rsp.out_transport_id   = tid_ff;
   assign rsp.out_datagroup_type = dgt_ff;
   assign rsp.overrun            = ovr_ff;
   assign rsp.last               = last_ff;

endmodule

>>> rtl/core/object_segmenter.sv
// ----------------------------------------------------------------------------
// object_segmenter: top level of the object segmenter
// Cuts an object byte stream into segments with two-byte headers.
// ----------------------------------------------------------------------------
// A data byte that continues a segment gives one response transfer; one that
// opens a segment gives three, since the single response port emits the two
// header bytes before it. The response port is the limit: the classifier
// takes one byte per cycle into a QUEUE_DEPTH-entry job queue while it has
// room, and the serializer drains one response transfer per cycle while ready
// is high. Each response carries the segment index (saturating at 32767), the
// last-segment and end-of-segment marks, the latched transport id and data
// group type, an overrun flag for bytes beyond the declared object length,
// and a last flag on the final transfer of each input byte.
// Write segment_size (index 0) and repetition_count (index 1) only while the
// block is idle; a segment_size of zero acts as one.
// ----------------------------------------------------------------------------
module object_segmenter #(
   parameter int QUEUE_DEPTH = objseg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   objseg_req_if.sink                          req_chan,
   objseg_rsp_if.source                        rsp_chan,
   input  logic                                csr_we,
   input  logic [objseg_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [objseg_pkg::LEN_BITS-1:0]     csr_wdata
);

   // configuration registers
   logic [objseg_pkg::LEN_BITS-1:0] seg_size_ff;
   logic [objseg_pkg::REP_BITS-1:0] rep_count_ff;

   // queue handshake between classifier and serializer
   logic                queue_full, queue_not_empty, push, pop;
   objseg_pkg::job_type push_job, head_job;

   // hold each register until written; decode the register index
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_size_ff  <= objseg_pkg::SEG_SIZE_RESET;
         rep_count_ff <= objseg_pkg::REP_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            objseg_pkg::CSR_SEG_SIZE:  seg_size_ff  <= csr_wdata;
            objseg_pkg::CSR_REP_COUNT: rep_count_ff <= csr_wdata[objseg_pkg::REP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // classify each accepted byte and advance the object/segment counters
   objseg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .segment_size     (seg_size_ff),
      .repetition_count (rep_count_ff),
      .queue_full       (queue_full),
      .push             (push),
      .job              (push_job)
   );

   // decouple input transfers from header insertion on the output side
   objseg_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   // expand each job into header bytes and the data byte
   objseg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

>>> tb/object_segmenter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// object_segmenter_tb: self-checking bench of the object segmenter
// Drives object byte streams into the request channel and checks every
// response transfer against an in-bench segmentation predictor. A directed
// table and a random part follow each other, with random gaps on both
// channels and register changes between phases.
// ----------------------------------------------------------------------------
module object_segmenter_tb;

   localparam int LEN_BITS     = objseg_pkg::LEN_BITS;
   localparam int OBJ_BITS     = objseg_pkg::OBJ_BITS;
   localparam int INDEX_BITS   = objseg_pkg::INDEX_BITS;
   localparam int TID_BITS     = objseg_pkg::TID_BITS;
   localparam int DGT_BITS     = objseg_pkg::DGT_BITS;
   localparam int REP_BITS     = objseg_pkg::REP_BITS;
   localparam int CSR_IDX_BITS = objseg_pkg::CSR_IDX_BITS;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 4;
   localparam int RANDOM_ITEMS   = 445;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 40;

   // one request item plus the few values typed in for the directed table
   typedef struct {
      logic                set_cfg;
      logic [LEN_BITS-1:0] cfg_size;
      logic [REP_BITS-1:0] cfg_rep;
      logic [7:0]          data;
      logic                first;
      logic [OBJ_BITS-1:0] len;
      logic [TID_BITS-1:0] tid;
      logic [DGT_BITS-1:0] dgt;
      logic                typed;
      logic [15:0]         exp_word;
      logic                exp_ovr;
   } stim_row_type;

   // one response transfer as the predictor sees it
   typedef struct packed {
      logic [7:0]            out_byte;
      logic                  is_header_byte;
      logic [INDEX_BITS-1:0] segment_index;
      logic                  last_segment;
      logic                  end_of_segment;
      logic [TID_BITS-1:0]   out_transport_id;
      logic [DGT_BITS-1:0]   out_datagroup_type;
      logic                  overrun;
      logic                  last;
   } seg_beat_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [LEN_BITS-1:0]     csr_wdata;

   objseg_req_if req_bus ();
   objseg_rsp_if rsp_bus ();

   object_segmenter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // --------------------------------------------------------------------------
   // Segmentation predictor: own copy of registers and object state
   // --------------------------------------------------------------------------
   logic [LEN_BITS-1:0]   pred_seg_size;
   logic [REP_BITS-1:0]   pred_rep;
   logic [OBJ_BITS-1:0]   obj_left;
   logic [LEN_BITS-1:0]   seg_left;
   logic [INDEX_BITS-1:0] seg_idx;
   logic [TID_BITS-1:0]   cur_tid;
   logic [DGT_BITS-1:0]   cur_dgt;

   seg_beat_type beats_due[$];   // responses still owed by the block
   stim_row_type row_in_flight;  // row on the request channel, updated with the bus
   int           mismatches = 0;
   int           items_sent = 0;
   bit           calm = 1'b0;    // suppress all idling on both channels
   int           stall_left = 0;

   function automatic void push_beat(input logic [7:0] value, input logic hdr,
                                     input logic lastseg, input logic eos,
                                     input logic ovr, input logic fin);
      seg_beat_type beat;
      beat = '{value, hdr, seg_idx, lastseg, eos, cur_tid, cur_dgt, ovr, fin};
      beats_due.insert(beats_due.size(), beat);
   endfunction

   // Work out the responses of one accepted byte and advance the object state.
   // Typed rows of the directed table replace the header word and the overrun
   // flag with the values written into the table.
   function automatic void predict_segment(input logic [7:0] d, input logic first,
                                           input logic [OBJ_BITS-1:0] len,
                                           input logic [TID_BITS-1:0] tid,
                                           input logic [DGT_BITS-1:0] dgt,
                                           input stim_row_type row);
      logic [LEN_BITS-1:0] size;
      logic [LEN_BITS-1:0] seglen;
      logic [15:0]         word;
      logic                lastseg;
      logic                ovr;
      if (first) begin
         obj_left = len;
         cur_tid  = tid;
         cur_dgt  = dgt;
         seg_idx  = '0;
         seg_left = '0;
      end
      // past the end of the object (or a zero-length one): pass through, flag it
      if (obj_left == '0) begin
         ovr = row.typed ? row.exp_ovr : 1'b1;
         push_beat(d, 1'b0, 1'b0, 1'b0, ovr, 1'b1);
         return;
      end
      // open a segment: two header bytes, most significant first
      if (seg_left == '0) begin
         size   = (pred_seg_size == '0) ? LEN_BITS'(1) : pred_seg_size;
         seglen = (obj_left < OBJ_BITS'(size)) ? obj_left[LEN_BITS-1:0] : size;
         if (!first && seg_idx != objseg_pkg::SEG_INDEX_MAX)
            seg_idx = seg_idx + INDEX_BITS'(1);
         seg_left = seglen;
         word     = row.typed ? row.exp_word : {pred_rep, seglen};
         lastseg  = (OBJ_BITS'(seg_left) == obj_left);
         push_beat(word[15:8], 1'b1, lastseg, 1'b0, 1'b0, 1'b0);
         push_beat(word[7:0],  1'b1, lastseg, 1'b0, 1'b0, 1'b0);
      end
      lastseg = (OBJ_BITS'(seg_left) == obj_left);
      ovr     = row.typed ? row.exp_ovr : 1'b0;
      push_beat(d, 1'b0, lastseg, seg_left == LEN_BITS'(1), ovr, 1'b1);
      seg_left = seg_left - LEN_BITS'(1);
      obj_left = obj_left - OBJ_BITS'(1);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endfunction

   // --------------------------------------------------------------------------
   // Monitor: predict on each request transfer, check each response transfer.
   // Everything is sampled at the rising edge, before this edge's updates land.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      seg_beat_type want;
      if (reset) begin
         pred_seg_size = objseg_pkg::SEG_SIZE_RESET;
         pred_rep      = objseg_pkg::REP_COUNT_RESET;
         obj_left      = '0;
         seg_left      = '0;
         seg_idx       = '0;
         cur_tid       = '0;
         cur_dgt       = '0;
         beats_due.delete();
      end else begin
         // mirror register writes; they only happen while the block is idle
         if (csr_we) begin
            case (csr_index)
               objseg_pkg::CSR_SEG_SIZE:  pred_seg_size = csr_wdata;
               objseg_pkg::CSR_REP_COUNT: pred_rep      = csr_wdata[REP_BITS-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            predict_segment(req_bus.data_byte, req_bus.first_byte, req_bus.object_length,
                            req_bus.transport_id, req_bus.datagroup_type, row_in_flight);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (beats_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $error("response transfer with nothing expected: out_byte 0x%0h",
                         rsp_bus.out_byte);
            end else begin
               want = beats_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_bus.out_byte);
               check_field("is_header_byte", want.is_header_byte, rsp_bus.is_header_byte);
               check_field("segment_index", want.segment_index, rsp_bus.segment_index);
               check_field("last_segment", want.last_segment, rsp_bus.last_segment);
               check_field("end_of_segment", want.end_of_segment, rsp_bus.end_of_segment);
               check_field("out_transport_id", want.out_transport_id,
                           rsp_bus.out_transport_id);
               check_field("out_datagroup_type", want.out_datagroup_type,
                           rsp_bus.out_datagroup_type);
               check_field("overrun", want.overrun, rsp_bus.overrun);
               check_field("last", want.last, rsp_bus.last);
            end
         end
      end
   end

   // Watchdog: end the run when no transfer moves for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d responses still due",
                  quiet_cycles, beats_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Idling: mostly short gaps, now and then a long one
   // --------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Response side: hold ready low for a random stall, then release it.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 2) == 0)
            stall_left = pick_gap();
      end
   end

   // --------------------------------------------------------------------------
   // Request side
   // --------------------------------------------------------------------------
   function automatic stim_row_type make_item(input logic [7:0] d, input logic first,
                                              input logic [OBJ_BITS-1:0] len,
                                              input logic [TID_BITS-1:0] tid,
                                              input logic [DGT_BITS-1:0] dgt);
      stim_row_type r;
      r          = '{default: '0};
      r.data     = d;
      r.first    = first;
      r.len      = len;
      r.tid      = tid;
      r.dgt      = dgt;
      return r;
   endfunction

   // Present one item after a random gap and hold it until the transfer.
   // Keep valid high across back-to-back items.
   task automatic send_item(input stim_row_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= r.data;
      req_bus.first_byte     <= r.first;
      req_bus.object_length  <= r.len;
      req_bus.transport_id   <= r.tid;
      req_bus.datagroup_type <= r.dgt;
      row_in_flight          <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every owed response has come out.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (beats_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on consecutive edges; call only while idle.
   task automatic set_config(input logic [LEN_BITS-1:0] size, input logic [REP_BITS-1:0] rep);
      csr_we    <= 1'b1;
      csr_index <= objseg_pkg::CSR_SEG_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      csr_index <= objseg_pkg::CSR_REP_COUNT;
      csr_wdata <= LEN_BITS'(rep);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Directed rows: set_cfg, size, rep, data, first, length, tid, type,
   // typed, header word, overrun. Header word and overrun count only where
   // typed is set.
   stim_row_type directed_rows [25] = '{
      // byte straight after reset: nothing declared, so it overruns
      '{0, 0,    0, 8'hA5, 0, 0,           16'h0000, 4'h0, 1, 16'h0000, 1},
      // one-byte object with all-ones id and type
      '{0, 0,    0, 8'hFF, 1, 1,           16'hFFFF, 4'hF, 1, 16'h0001, 0},
      '{0, 0,    0, 8'h00, 0, 0,           16'h0000, 4'h0, 1, 16'h0000, 1},
      // zero object length: latch id and type, then overrun
      '{0, 0,    0, 8'h5A, 1, 0,           16'h1234, 4'h3, 1, 16'h0000, 1},
      '{0, 0,    0, 8'h00, 1, 3,           16'h0000, 4'h0, 1, 16'h0003, 0},
      '{0, 0,    0, 8'h7F, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0},
      '{0, 0,    0, 8'h80, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0},
      // largest object length: segment capped at the reset size of 1024
      '{0, 0,    0, 8'h55, 1, 28'hFFFFFFF, 16'hAAAA, 4'h5, 1, 16'h0400, 0},
      '{0, 0,    0, 8'h01, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0},
      // new start in the middle of an object abandons it
      '{0, 0,    0, 8'hC3, 1, 2,           16'h5555, 4'hA, 1, 16'h0002, 0},
      '{0, 0,    0, 8'h3C, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0},
      // one-byte segments, top repetition count: every byte opens a segment
      '{1, 1,    7, 8'h11, 1, 3,           16'h0F0F, 4'h1, 1, 16'hE001, 0},
      '{0, 0,    0, 8'h22, 0, 0,           16'h0000, 4'h0, 1, 16'hE001, 0},
      '{0, 0,    0, 8'h33, 0, 0,           16'h0000, 4'h0, 1, 16'hE001, 0},
      '{0, 0,    0, 8'h99, 0, 0,           16'h0000, 4'h0, 1, 16'h0000, 1},
      // segment size zero acts as one
      '{1, 0,    5, 8'h09, 1, 2,           16'hF0F0, 4'hE, 1, 16'hA001, 0},
      '{0, 0,    0, 8'h08, 0, 0,           16'h0000, 4'h0, 1, 16'hA001, 0},
      // largest segment size
      '{1, 8191, 0, 8'h12, 1, 8192,        16'h7FFF, 4'h7, 1, 16'h1FFF, 0},
      '{0, 0,    0, 8'h56, 1, 8191,        16'h8000, 4'h8, 1, 16'h1FFF, 0},
      // register change mid-object, then a short last segment
      '{1, 4,    2, 8'h77, 1, 6,           16'h4242, 4'h2, 1, 16'h4004, 0},
      '{0, 0,    0, 8'h78, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0},
      '{0, 0,    0, 8'h79, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0},
      '{0, 0,    0, 8'h7A, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0},
      '{0, 0,    0, 8'h7B, 0, 0,           16'h0000, 4'h0, 1, 16'h4002, 0},
      '{0, 0,    0, 8'h7C, 0, 0,           16'h0000, 4'h0, 0, 16'h0000, 0}
   };

   initial begin
      int                  random_start;
      int                  pick;
      int                  olen;
      int                  cut;
      logic [LEN_BITS-1:0] size;
      logic [TID_BITS-1:0] tid;
      logic [DGT_BITS-1:0] dgt;
      logic [OBJ_BITS-1:0] noise_len;

      // known values on every input from time zero
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = objseg_pkg::CSR_SEG_SIZE;
      csr_wdata              = '0;
      req_bus.valid          = 1'b0;
      req_bus.data_byte      = '0;
      req_bus.first_byte     = 1'b0;
      req_bus.object_length  = '0;
      req_bus.transport_id   = '0;
      req_bus.datagroup_type = '0;
      rsp_bus.ready          = 1'b0;
      row_in_flight          = '{default: '0};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, reset register values until the first row that sets them
      foreach (directed_rows[k]) begin
         if (directed_rows[k].set_cfg) begin
            drain_results();
            set_config(directed_rows[k].cfg_size, directed_rows[k].cfg_rep);
         end
         send_item(directed_rows[k]);
      end

      // random phases: new registers, then a handful of objects each
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         drain_results();
         pick = $urandom_range(0, 9);
         case (pick)
            0:       size = '0;
            1:       size = LEN_BITS'(1);
            2:       size = LEN_BITS'(8191);
            3:       size = LEN_BITS'($urandom_range(13, 300));
            default: size = LEN_BITS'($urandom_range(2, 12));
         endcase
         set_config(size, REP_BITS'($urandom_range(0, 7)));
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 6)) begin
            tid  = TID_BITS'($urandom);
            dgt  = DGT_BITS'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               // well-formed object, sometimes cut short by the next start
               olen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                  : $urandom_range(1, 40);
               cut  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, olen) : olen;
               for (int i = 0; i < cut; i++) begin
                  // now and then stall the sender mid-object until all is out
                  if (i == cut / 2 && $urandom_range(0, 19) == 0)
                     drain_results();
                  send_item(make_item(8'($urandom), i == 0, OBJ_BITS'(olen), tid, dgt));
               end
               // trailing bytes beyond a finished object
               if (cut == olen && $urandom_range(0, 4) == 0)
                  repeat ($urandom_range(1, 3))
                     send_item(make_item(8'($urandom), 1'b0, OBJ_BITS'($urandom),
                                         TID_BITS'($urandom), DGT_BITS'($urandom)));
            end else begin
               // noise: random start bit and any declared length, zero included
               repeat ($urandom_range(1, 4)) begin
                  noise_len = ($urandom_range(0, 3) == 0) ? '0 : OBJ_BITS'($urandom);
                  send_item(make_item(8'($urandom), 1'($urandom_range(0, 1)), noise_len,
                                      TID_BITS'($urandom), DGT_BITS'($urandom)));
               end
            end
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
rtl/core/objseg_pkg.sv
rtl/core/objseg_if.sv
rtl/core/objseg_front.sv
rtl/core/objseg_fifo.sv
rtl/core/objseg_back.sv
rtl/core/object_segmenter.sv
tb/object_segmenter_tb.sv
